// ===== hdl/assert_macros.svh =====
// assertion macros shared by the search block
// no dependencies, included by the modules that assert
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define KSS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that must hold in and out of reset
`define KSS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/kss_pkg.sv =====
// shared types and codes for the substring search block
// no dependencies
package kss_pkg;

    localparam int BYTE_W   = 8;
    localparam int START_W  = 16;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_PAT_LONG  = 2'd2,
        ST_TEXT_LONG = 2'd3
    } kss_status_t;

    typedef struct packed {
        kss_status_t              status;
        logic [START_W-1:0]       match_start;
    } kss_result_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic                     clear;
        logic                     step;
        logic [BYTE_W-1:0]        data;
    } kss_cell_ctrl_t;

endpackage

// ===== hdl/kss_req_if.sv =====
// request channel: pattern and text bytes
// depends on kss_pkg
interface kss_req_if;
    logic                        valid;
    logic                        ready;
    logic                        req_type;
    logic [kss_pkg::BYTE_W-1:0]  byte_value;
    logic                        is_last;

    modport source (output valid, output req_type, output byte_value, output is_last,
                    input ready);
    modport sink   (input valid, input req_type, input byte_value, input is_last,
                    output ready);
endinterface

// ===== hdl/kss_res_if.sv =====
// result channel: search outcome and match offset
// depends on kss_pkg
interface kss_res_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [kss_pkg::START_W-1:0] match_start;

    modport source (output valid, output status, output match_start, input ready);
    modport sink   (input valid, input status, input match_start, output ready);
endinterface

// ===== hdl/kss_cell.sv =====
// one cell of the matcher row: a pattern byte and its partial-match flag
// depends on kss_pkg
module kss_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  kss_pkg::kss_cell_ctrl_t ctrl,
    input  logic                    load,
    input  logic                    prev_hit,
    output logic                    hit,
    output logic                    hit_step
);

    logic [kss_pkg::BYTE_W-1:0] byte_reg;
    logic                       hit_reg;
    logic                       hit_next;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= ctrl.data;
        end
    end

    // text ending here matches the pattern up to and including this cell
    assign hit_step = prev_hit && (byte_reg == ctrl.data);

    always_comb
    begin
        if (ctrl.clear)
        begin
            hit_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            hit_next = hit_step;
        end
        else
        begin
            hit_next = hit_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

// ===== hdl/kss_out_reg.sv =====
// output register for the result channel
// depends on kss_pkg and kss_res_if
module kss_out_reg (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  kss_pkg::kss_result_t result,
    output logic                 can_push,
    kss_res_if.source            res
);

    logic                 valid_reg;
    logic                 valid_next;
    kss_pkg::kss_result_t result_reg;

    assign can_push = !valid_reg || res.ready;

    always_comb
    begin
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            result_reg <= result;
        end
    end

    assign res.valid       = valid_reg;
    assign res.status      = result_reg.status;
    assign res.match_start = result_reg.match_start;

endmodule

// ===== hdl/kmp_substring_search.sv =====
// top level of the first-occurrence substring search
// depends on kss_pkg, kss_req_if, kss_res_if, kss_cell, kss_out_reg, assert_macros.svh
//
// Pattern items (req_type 0) load one byte each into a row of PATTERN_MAX cells;
// text items (req_type 1) are then compared against every cell at once, each
// cell passing its partial-match flag to the next, so the first full match is
// seen in the cycle its last byte arrives. Each text, closed by an item with
// is_last set, gives exactly one result item: found with its start offset,
// not found, pattern too long or text too long; after a result the rest of
// that text is swallowed. One item is accepted per cycle while input ready is
// high, and a result appears in the output register on the next cycle.
// The only limit is the output register: while a result waits there unread,
// input ready falls. The pattern and match state need no clearing pass after
// reset.
`include "assert_macros.svh"

module kmp_substring_search #(
    parameter int PATTERN_MAX = 16,
    parameter int TEXT_MAX    = 65536
) (
    input  logic       clk,
    input  logic       rst_n,
    kss_req_if.sink    req,
    kss_res_if.source  res
);

    localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
    localparam int POS_W  = $clog2(TEXT_MAX + 1);
    localparam int CALC_W = (POS_W > kss_pkg::START_W) ?
                            ((POS_W > LEN_W) ? POS_W : LEN_W) :
                            ((kss_pkg::START_W > LEN_W) ? kss_pkg::START_W : LEN_W);

    logic [LEN_W-1:0] len_reg, len_next;
    logic             complete_reg, complete_next;
    logic             too_long_reg, too_long_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             finished_reg, finished_next;

    logic             acc;
    logic             can_push;
    logic             emit;
    logic [LEN_W-1:0] base_len;
    logic             base_full;
    logic             match;
    logic [CALC_W-1:0] start_calc;

    kss_pkg::kss_cell_ctrl_t cell_ctrl;
    kss_pkg::kss_result_t    result;

    logic [PATTERN_MAX-1:0] load_vec;
    logic [PATTERN_MAX-1:0] hit_vec;
    logic [PATTERN_MAX-1:0] step_vec;
    logic [PATTERN_MAX-1:0] tail_sel;

    assign req.ready = can_push;
    assign acc       = req.valid && req.ready;

    // a pattern byte after a completed pattern starts a fresh one
    assign base_len  = complete_reg ? '0 : len_reg;
    assign base_full = (base_len >= LEN_W'(PATTERN_MAX));

    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_MAX; gi++)
        begin : g_cell
            logic prev_hit;

            if (gi == 0)
            begin : g_head
                assign prev_hit = 1'b1;
            end
            else
            begin : g_link
                assign prev_hit = hit_vec[gi-1];
            end

            assign load_vec[gi] = acc && !req.req_type && !base_full &&
                                  (base_len == LEN_W'(gi));
            assign tail_sel[gi] = (len_reg == LEN_W'(gi + 1));

            kss_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .load     (load_vec[gi]),
                .prev_hit (prev_hit),
                .hit      (hit_vec[gi]),
                .hit_step (step_vec[gi])
            );
        end
    endgenerate

    assign match      = |(step_vec & tail_sel);
    assign start_calc = CALC_W'(pos_reg) + CALC_W'(1) - CALC_W'(len_reg);

    always_comb
    begin
        len_next        = len_reg;
        complete_next   = complete_reg;
        too_long_next   = too_long_reg;
        pos_next        = pos_reg;
        finished_next   = finished_reg;
        cell_ctrl.clear = 1'b0;
        cell_ctrl.step  = 1'b0;
        cell_ctrl.data  = req.byte_value;
        emit            = 1'b0;
        result.status      = kss_pkg::ST_FOUND;
        result.match_start = '0;

        if (acc)
        begin
            if (!req.req_type)
            begin
                cell_ctrl.clear = 1'b1;
                pos_next        = '0;
                finished_next   = 1'b0;
                complete_next   = req.is_last;
                too_long_next   = complete_reg ? 1'b0 : too_long_reg;
                if (base_full)
                begin
                    too_long_next = 1'b1;
                    len_next      = base_len;
                end
                else
                begin
                    len_next = base_len + LEN_W'(1);
                end
            end
            else
            begin
                complete_next = 1'b1;
                if (!finished_reg)
                begin
                    if (too_long_reg)
                    begin
                        emit          = 1'b1;
                        result.status = kss_pkg::ST_PAT_LONG;
                    end
                    else if (len_reg == '0)
                    begin
                        emit          = 1'b1;
                        result.status = kss_pkg::ST_FOUND;
                    end
                    else if (pos_reg >= POS_W'(TEXT_MAX))
                    begin
                        emit          = 1'b1;
                        result.status = kss_pkg::ST_TEXT_LONG;
                    end
                    else
                    begin
                        cell_ctrl.step = 1'b1;
                        pos_next       = pos_reg + POS_W'(1);
                        if (match)
                        begin
                            emit               = 1'b1;
                            result.status      = kss_pkg::ST_FOUND;
                            result.match_start = start_calc[kss_pkg::START_W-1:0];
                        end
                    end
                end

                if (req.is_last)
                begin
                    if (!finished_reg && !emit)
                    begin
                        emit          = 1'b1;
                        result.status = kss_pkg::ST_NOT_FOUND;
                    end
                    cell_ctrl.clear = 1'b1;
                    pos_next        = '0;
                    finished_next   = 1'b0;
                end
                else
                begin
                    finished_next = finished_reg || emit;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            complete_reg <= 1'b0;
            too_long_reg <= 1'b0;
            pos_reg      <= '0;
            finished_reg <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            complete_reg <= complete_next;
            too_long_reg <= too_long_next;
            pos_reg      <= pos_next;
            finished_reg <= finished_next;
        end
    end

    kss_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (emit),
        .result   (result),
        .can_push (can_push),
        .res      (res)
    );

    `KSS_ASSERT(a_emit_text_only, clk, rst_n, emit |-> (acc && req.req_type), "result without text item")
    `KSS_ASSERT(a_one_per_text, clk, rst_n, emit |-> !finished_reg, "second result for one text")
    `KSS_ASSERT(a_pattern_resets, clk, rst_n, (acc && !req.req_type) |=> (!finished_reg && pos_reg == '0), "pattern item left search state")
    `KSS_ASSERT(a_overflow_len, clk, rst_n, too_long_reg |-> (len_reg == LEN_W'(PATTERN_MAX)), "overflow flag with short pattern")
    `KSS_ASSERT(a_pos_bound, clk, rst_n, pos_reg <= POS_W'(TEXT_MAX), "text position beyond limit")

endmodule
